// ===== rtl/core/mps_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mps_pkg
// Shared widths, reset values, register codes and helpers for the streaming
// 2-D max pooling unit.
// ============================================================================
package mps_pkg;

    // Default module parameters
    localparam int DEF_MAX_CHANNELS  = 16;
    localparam int DEF_MAX_OUT_WIDTH = 64;
    localparam int DEF_DATA_WIDTH    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Register field widths
    localparam int CC_W  = 5;   // channel_count
    localparam int DIM_W = 7;   // in_height, in_width
    localparam int WIN_W = 3;   // window_rows, window_cols

    // Position counter widths
    localparam int POS_W  = 6;  // row, column, output column
    localparam int CHAN_W = 4;  // channel
    localparam int SUB_W  = 2;  // position inside the window
    localparam int SUM_W  = 8;  // window fit sums
    localparam int CMP_W  = 10; // output column against MAX_OUT_WIDTH

    // Clamp limits
    localparam logic [DIM_W-1:0] CHAN_LIMIT = 7'd16;
    localparam logic [DIM_W-1:0] DIM_LIMIT  = 7'd64;
    localparam logic [DIM_W-1:0] WIN_LIMIT  = 7'd4;

    // Register reset values
    localparam logic [CC_W-1:0]  RST_CHANNEL_COUNT = 5'd6;
    localparam logic [DIM_W-1:0] RST_IN_HEIGHT     = 7'd28;
    localparam logic [DIM_W-1:0] RST_IN_WIDTH      = 7'd28;
    localparam logic [WIN_W-1:0] RST_WINDOW_ROWS   = 3'd2;
    localparam logic [WIN_W-1:0] RST_WINDOW_COLS   = 3'd2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_IN_HEIGHT     = 3'd1,
        REG_IN_WIDTH      = 3'd2,
        REG_WINDOW_ROWS   = 3'd3,
        REG_WINDOW_COLS   = 3'd4
    } t_cfg_reg;

    // Control flags of an item in the compare stage
    typedef struct packed {
        logic hit;    // item lies inside a whole window
        logic first;  // top-left element of its window
        logic emit;   // bottom-right element of its window
        logic last;   // final result of the frame
    } t_item_ctl;

    // Zero reads as one, values above the limit saturate
    function automatic logic [DIM_W-1:0] clamp_cfg(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/max_pool_2d_stream_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// max_pool_2d_stream_unit
// Non-overlapping 2-D max pooling over a feature map streamed in row,
// column, channel order, one result per channel for each whole window.
// ============================================================================
// The unit takes one sample per clock cycle unless the result channel stalls;
// a result passes the compare stage and the output register. The rate is set
// by the line store, a single memory of MAX_OUT_WIDTH x MAX_CHANNELS entries
// with one read and one write port: the entry is read in the accept cycle and
// written back from the compare stage, with a bypass when two samples in a row
// hit the same entry. The store needs no clearing pass after reset, since the
// first element of every window loads its entry. Writing any known register
// restarts the frame; the user writes registers only while the unit is idle,
// which the unit itself does not enforce. Partial windows at the bottom and
// right edges are dropped, and o_frame_end marks the last result of each frame.
module max_pool_2d_stream_unit #(
    parameter int MAX_CHANNELS  = mps_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_OUT_WIDTH = mps_pkg::DEF_MAX_OUT_WIDTH,
    parameter int DATA_WIDTH    = mps_pkg::DEF_DATA_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Sample input channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [DATA_WIDTH-1:0]         i_sample,
    // Result output channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [DATA_WIDTH-1:0]         o_pooled,
    output logic                                 o_frame_end
);
    import mps_pkg::*;

    localparam int DEPTH  = MAX_OUT_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [CC_W-1:0]  r_channel_count;
    logic [DIM_W-1:0] r_in_height;
    logic [DIM_W-1:0] r_in_width;
    logic [WIN_W-1:0] r_window_rows;
    logic [WIN_W-1:0] r_window_cols;

    // Frame position counters
    logic [POS_W-1:0]  r_row_pos,  n_row_pos;
    logic [POS_W-1:0]  r_row_base, n_row_base;
    logic [SUB_W-1:0]  r_row_sub,  n_row_sub;
    logic [POS_W-1:0]  r_col_pos,  n_col_pos;
    logic [POS_W-1:0]  r_col_base, n_col_base;
    logic [SUB_W-1:0]  r_col_sub,  n_col_sub;
    logic [POS_W-1:0]  r_out_col,  n_out_col;
    logic [CHAN_W-1:0] r_chan_pos, n_chan_pos;

    // Compare stage
    logic                         r_s1_valid;
    t_item_ctl                    r_s1_ctl, n_s1_ctl;
    logic signed [DATA_WIDTH-1:0] r_s1_sample;
    logic [ADDR_W-1:0]            r_s1_addr;
    logic                         r_s1_fwd;
    logic signed [DATA_WIDTH-1:0] r_fwd_data;
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    // Line store
    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];

    // Output register
    logic                         r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_pooled;
    logic                         r_out_frame_end;

    // Effective geometry
    logic [DIM_W-1:0]  nch, h_eff, w_eff, wr_eff, wc_eff;
    logic [CHAN_W-1:0] chan_last;
    logic [POS_W-1:0]  h_last, w_last;
    logic [SUB_W-1:0]  wr_last, wc_last;

    logic              in_accept;
    logic              s1_free;
    logic [ADDR_W-1:0] rd_addr;
    logic              row_fit, col_fit, col_cap, row_final, col_final;
    logic [CMP_W-1:0]  out_col_w;
    logic signed [DATA_WIDTH-1:0] s1_old, s1_new;
    logic              s1_write;

    // Clamp register values to their working ranges
    always_comb begin
        nch = clamp_cfg({{(DIM_W-CC_W){1'b0}}, r_channel_count}, CHAN_LIMIT);
        if (nch > DIM_W'(MAX_CHANNELS)) begin
            nch = DIM_W'(MAX_CHANNELS);
        end
        h_eff     = clamp_cfg(r_in_height, DIM_LIMIT);
        w_eff     = clamp_cfg(r_in_width, DIM_LIMIT);
        wr_eff    = clamp_cfg({{(DIM_W-WIN_W){1'b0}}, r_window_rows}, WIN_LIMIT);
        wc_eff    = clamp_cfg({{(DIM_W-WIN_W){1'b0}}, r_window_cols}, WIN_LIMIT);
        chan_last = CHAN_W'(nch - 7'd1);
        h_last    = POS_W'(h_eff - 7'd1);
        w_last    = POS_W'(w_eff - 7'd1);
        wr_last   = SUB_W'(wr_eff - 7'd1);
        wc_last   = SUB_W'(wc_eff - 7'd1);
    end

    // Classify the incoming item against whole windows
    always_comb begin
        out_col_w = CMP_W'(r_out_col);
        row_fit   = (SUM_W'(r_row_base) + SUM_W'(wr_eff)) <= SUM_W'(h_eff);
        col_fit   = (SUM_W'(r_col_base) + SUM_W'(wc_eff)) <= SUM_W'(w_eff);
        col_cap   = out_col_w < CMP_W'(MAX_OUT_WIDTH);
        row_final = (SUM_W'(r_row_base) + SUM_W'(wr_eff) + SUM_W'(wr_eff))
                    > SUM_W'(h_eff);
        col_final = ((SUM_W'(r_col_base) + SUM_W'(wc_eff) + SUM_W'(wc_eff))
                    > SUM_W'(w_eff)) || (out_col_w == CMP_W'(MAX_OUT_WIDTH - 1));

        n_s1_ctl.hit   = row_fit && col_fit && col_cap;
        n_s1_ctl.first = (r_row_sub == '0) && (r_col_sub == '0);
        n_s1_ctl.emit  = n_s1_ctl.hit && (r_row_sub == wr_last)
                         && (r_col_sub == wc_last);
        n_s1_ctl.last  = row_final && col_final && (r_chan_pos == chan_last);

        rd_addr = ADDR_W'(int'(r_out_col) * MAX_CHANNELS + int'(r_chan_pos));
    end

    // Advance the frame position by one item
    always_comb begin
        n_row_pos  = r_row_pos;
        n_row_base = r_row_base;
        n_row_sub  = r_row_sub;
        n_col_pos  = r_col_pos;
        n_col_base = r_col_base;
        n_col_sub  = r_col_sub;
        n_out_col  = r_out_col;
        n_chan_pos = r_chan_pos + 1'b1;
        if (r_chan_pos == chan_last) begin
            n_chan_pos = '0;
            n_col_pos  = r_col_pos + 1'b1;
            n_col_sub  = r_col_sub + 1'b1;
            if (r_col_sub == wc_last) begin
                n_col_sub  = '0;
                n_out_col  = r_out_col + 1'b1;
                n_col_base = r_col_pos + 1'b1;
            end
            if (r_col_pos == w_last) begin
                n_col_pos  = '0;
                n_col_sub  = '0;
                n_col_base = '0;
                n_out_col  = '0;
                n_row_pos  = r_row_pos + 1'b1;
                n_row_sub  = r_row_sub + 1'b1;
                if (r_row_sub == wr_last) begin
                    n_row_sub  = '0;
                    n_row_base = r_row_pos + 1'b1;
                end
                if (r_row_pos == h_last) begin
                    n_row_pos  = '0;
                    n_row_sub  = '0;
                    n_row_base = '0;
                end
            end
        end
    end

    // Compare stage: keep the larger value, bypass a same-entry write
    always_comb begin
        s1_old = r_s1_fwd ? r_fwd_data : r_rd_data;
        if (r_s1_ctl.first || (r_s1_sample > s1_old)) begin
            s1_new = r_s1_sample;
        end else begin
            s1_new = s1_old;
        end
        s1_free   = !r_s1_valid || !r_s1_ctl.emit || !r_out_valid || i_ready;
        s1_write  = r_s1_valid && s1_free && r_s1_ctl.hit;
        in_accept = i_valid && s1_free;
    end

    assign o_ready     = s1_free;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_pooled    = r_out_pooled;
    assign o_frame_end = r_out_frame_end;

    // Configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_in_height     <= RST_IN_HEIGHT;
            r_in_width      <= RST_IN_WIDTH;
            r_window_rows   <= RST_WINDOW_ROWS;
            r_window_cols   <= RST_WINDOW_COLS;
            r_row_pos       <= '0;
            r_row_base      <= '0;
            r_row_sub       <= '0;
            r_col_pos       <= '0;
            r_col_base      <= '0;
            r_col_sub       <= '0;
            r_out_col       <= '0;
            r_chan_pos      <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CC_W-1:0];
                REG_IN_HEIGHT:     r_in_height     <= i_cfg_data[DIM_W-1:0];
                REG_IN_WIDTH:      r_in_width      <= i_cfg_data[DIM_W-1:0];
                REG_WINDOW_ROWS:   r_window_rows   <= i_cfg_data[WIN_W-1:0];
                REG_WINDOW_COLS:   r_window_cols   <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
            // Restart the frame on any known register
            if (i_cfg_index <= REG_WINDOW_COLS) begin
                r_row_pos  <= '0;
                r_row_base <= '0;
                r_row_sub  <= '0;
                r_col_pos  <= '0;
                r_col_base <= '0;
                r_col_sub  <= '0;
                r_out_col  <= '0;
                r_chan_pos <= '0;
            end
        end else if (in_accept) begin
            r_row_pos  <= n_row_pos;
            r_row_base <= n_row_base;
            r_row_sub  <= n_row_sub;
            r_col_pos  <= n_col_pos;
            r_col_base <= n_col_base;
            r_col_sub  <= n_col_sub;
            r_out_col  <= n_out_col;
            r_chan_pos <= n_chan_pos;
        end
    end

    // Line store: read on accept, write back from the compare stage
    always_ff @(posedge i_clk) begin
        if (s1_write) begin
            r_mem[r_s1_addr] <= s1_new;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Load the compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctl    <= n_s1_ctl;
            r_s1_sample <= i_sample;
            r_s1_addr   <= rd_addr;
            r_s1_fwd    <= s1_write && (r_s1_addr == rd_addr);
            r_fwd_data  <= s1_new;
        end
    end

    // Hold the result until taken, then load the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_free && r_s1_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_free && r_s1_ctl.emit) begin
            r_out_pooled    <= s1_new;
            r_out_frame_end <= r_s1_ctl.last;
        end
    end

endmodule

// ===== bench/max_pool_2d_stream_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// max_pool_2d_stream_checker
// Watches the configuration, sample and result channels of the max pooling
// unit, keeps its own copy of the registers, the frame position and the line
// store, predicts every pooled result and compares it with what leaves the
// unit. Reports the number of failures and the results still outstanding.
// ============================================================================
module max_pool_2d_stream_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Sample channel
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic signed [mps_pkg::DEF_DATA_WIDTH-1:0] i_in_sample,
    // Result channel
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [mps_pkg::DEF_DATA_WIDTH-1:0] i_out_pooled,
    input  logic                                  i_out_frame_end,
    // Status to the test top
    output int                                    o_fail_count,
    output int                                    o_pending
);

    localparam int DW = mps_pkg::DEF_DATA_WIDTH;
    localparam int CH = mps_pkg::DEF_MAX_CHANNELS;
    localparam int OW = mps_pkg::DEF_MAX_OUT_WIDTH;

    typedef struct packed {
        logic signed [DW-1:0] pooled;
        logic                 frame_end;
    } t_pool_result;

    // Pooled values still owed by the unit, oldest first
    t_pool_result pooled_due[$];

    // Running window maxima, one per output column and channel
    logic signed [DW-1:0] line_max [0:CH*OW-1];

    // Register copies
    logic [mps_pkg::CC_W-1:0]  chan_reg;
    logic [mps_pkg::DIM_W-1:0] height_reg;
    logic [mps_pkg::DIM_W-1:0] width_reg;
    logic [mps_pkg::WIN_W-1:0] wrows_reg;
    logic [mps_pkg::WIN_W-1:0] wcols_reg;

    // Frame position
    int row_pos;
    int col_pos;
    int chan_pos;
    int row_sub;
    int col_sub;
    int out_col;

    int mismatches = 0;

    // Zero counts as one, larger values saturate
    function automatic int fit(input int v, input int hi);
        if (v == 0) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    task automatic restart_frame();
        row_pos  = 0;
        col_pos  = 0;
        chan_pos = 0;
        row_sub  = 0;
        col_sub  = 0;
        out_col  = 0;
    endtask

    // Fold one sample into the line store and queue the result it completes
    task automatic pool_sample(input logic signed [DW-1:0] v);
        int nch;
        int h;
        int w;
        int wr;
        int wc;
        int oh;
        int ow;
        int idx;
        t_pool_result res;
        nch = fit(int'(chan_reg), CH);
        h   = fit(int'(height_reg), 64);
        w   = fit(int'(width_reg), 64);
        wr  = fit(int'(wrows_reg), 4);
        wc  = fit(int'(wcols_reg), 4);
        oh  = h / wr;
        ow  = w / wc;
        if (ow > OW) begin
            ow = OW;
        end

        // Update the entry for samples inside whole windows only
        if (row_pos < oh * wr && col_pos < ow * wc && out_col < OW) begin
            idx = out_col * CH + chan_pos;
            if ((row_sub == 0 && col_sub == 0) || v > line_max[idx]) begin
                line_max[idx] = v;
            end
            if (row_sub == wr - 1 && col_sub == wc - 1) begin
                res.pooled    = line_max[idx];
                res.frame_end = (row_pos >= (oh - 1) * wr) && (out_col == ow - 1) &&
                                (chan_pos == nch - 1);
                pooled_due.push_back(res);
            end
        end

        // Advance channel, then column, then row
        chan_pos++;
        if (chan_pos >= nch) begin
            chan_pos = 0;
            col_pos++;
            col_sub++;
            if (col_sub >= wc) begin
                col_sub = 0;
                out_col++;
            end
            if (col_pos >= w) begin
                col_pos = 0;
                col_sub = 0;
                out_col = 0;
                row_pos++;
                row_sub++;
                if (row_sub >= wr) begin
                    row_sub = 0;
                end
                if (row_pos >= h) begin
                    row_pos = 0;
                    row_sub = 0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_pool_result want;
        if (!i_rst_n) begin
            chan_reg   = mps_pkg::RST_CHANNEL_COUNT;
            height_reg = mps_pkg::RST_IN_HEIGHT;
            width_reg  = mps_pkg::RST_IN_WIDTH;
            wrows_reg  = mps_pkg::RST_WINDOW_ROWS;
            wcols_reg  = mps_pkg::RST_WINDOW_COLS;
            restart_frame();
            pooled_due.delete();
        end else begin
            // Apply register writes; a known index restarts the frame
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mps_pkg::REG_CHANNEL_COUNT: begin
                        chan_reg = i_cfg_data[mps_pkg::CC_W-1:0];
                        restart_frame();
                    end
                    mps_pkg::REG_IN_HEIGHT: begin
                        height_reg = i_cfg_data[mps_pkg::DIM_W-1:0];
                        restart_frame();
                    end
                    mps_pkg::REG_IN_WIDTH: begin
                        width_reg = i_cfg_data[mps_pkg::DIM_W-1:0];
                        restart_frame();
                    end
                    mps_pkg::REG_WINDOW_ROWS: begin
                        wrows_reg = i_cfg_data[mps_pkg::WIN_W-1:0];
                        restart_frame();
                    end
                    mps_pkg::REG_WINDOW_COLS: begin
                        wcols_reg = i_cfg_data[mps_pkg::WIN_W-1:0];
                        restart_frame();
                    end
                    default: begin
                    end
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                pool_sample(i_in_sample);
            end

            // Compare each result with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pooled_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s %0d frame_end %0b",
                             $time, "actual pooled", i_out_pooled, i_out_frame_end);
                end else begin
                    want = pooled_due.pop_front();
                    if (i_out_pooled !== want.pooled) begin
                        mismatches++;
                        $display("%0t: pooled mismatch, expected %0d, actual %0d",
                                 $time, want.pooled, i_out_pooled);
                    end
                    if (i_out_frame_end !== want.frame_end) begin
                        mismatches++;
                        $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                                 $time, want.frame_end, i_out_frame_end);
                    end
                end
            end
        end
        o_pending    <= pooled_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/max_pool_2d_stream_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// max_pool_2d_stream_unit_test
// Stimulus and verdict for the streaming max pooling unit. Runs a short
// directed set (register zeros, extreme samples, partial windows, a map
// smaller than its window), then random phases with random register settings
// and random sample streams under bursty input and stalling output.
// ============================================================================
module max_pool_2d_stream_unit_test;

    localparam int DW           = mps_pkg::DEF_DATA_WIDTH;
    localparam int CW           = mps_pkg::CFG_DATA_W;
    localparam int IW           = mps_pkg::CFG_IDX_W;
    localparam int RANDOM_ITEMS = 1450;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [mps_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [mps_pkg::CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                              i_valid     = 1'b0;
    logic                              o_ready;
    logic signed [DW-1:0]              i_sample    = '0;
    logic                              o_valid;
    logic                              i_ready     = 1'b0;
    logic signed [DW-1:0]              o_pooled;
    logic                              o_frame_end;

    int fail_count;
    int pending;
    int results_seen = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit pressure_on  = 1'b0;
    bit hold_done    = 1'b0;

    max_pool_2d_stream_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pooled    (o_pooled),
        .o_frame_end (o_frame_end)
    );

    max_pool_2d_stream_checker pool_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_sample     (i_sample),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_pooled    (o_pooled),
        .i_out_frame_end (o_frame_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Count delivered results for the long hold-off trigger
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // Stall the result channel in runs of different styles
    initial begin
        int mode;
        int run;
        forever begin
            // Hold off once for a long stretch while items keep coming
            if (pressure_on && !hold_done && results_seen >= 40 && i_valid) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(10, 80);
            repeat (run) begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 1) == 1);
                    2:       i_ready <= ($urandom_range(0, 4) != 0);
                    default: i_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [mps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mps_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all five registers with raw values
    task automatic set_map(input int cc, input int h, input int w, input int wr, input int wc);
        write_reg(mps_pkg::REG_CHANNEL_COUNT, CW'(cc));
        write_reg(mps_pkg::REG_IN_HEIGHT, CW'(h));
        write_reg(mps_pkg::REG_IN_WIDTH, CW'(w));
        write_reg(mps_pkg::REG_WINDOW_ROWS, CW'(wr));
        write_reg(mps_pkg::REG_WINDOW_COLS, CW'(wc));
        end_writes();
    endtask

    // Offer one item, then keep to the burst and gap pattern
    task automatic offer_sample(input logic signed [DW-1:0] v);
        int gap;
        i_valid  <= 1'b1;
        i_sample <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // Drain all owed results, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] pick_sample();
        logic signed [DW-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = {1'b1, {(DW-1){1'b0}}};
            1:       v = {1'b0, {(DW-1){1'b1}}};
            2, 3:    v = DW'(int'($urandom_range(0, 8)) - 4);
            default: v = DW'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Height or width: mostly small, sometimes the extremes or raw overflow
    task automatic pick_dim(output int eff, output logic [mps_pkg::CFG_DATA_W-1:0] raw);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: eff = $urandom_range(1, 8);
            7:                   eff = $urandom_range(1, 64);
            8:                   eff = 1;
            default:             eff = 64;
        endcase
        raw = CW'(eff);
        if (eff == 1 && $urandom_range(0, 1) == 1) begin
            raw = '0;
        end
        if (eff == 64 && $urandom_range(0, 1) == 1) begin
            raw = CW'($urandom_range(65, 127));
        end
    endtask

    initial begin
        int eff_cc;
        int eff_h;
        int eff_w;
        int eff_wr;
        int eff_wc;
        int frame;
        int n_items;
        int sent;
        logic [4:0] phase_mask;
        logic [mps_pkg::CFG_DATA_W-1:0] raw;
        logic [mps_pkg::CFG_IDX_W-1:0] bad_index;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero registers read as one: every sample is its own window
        set_map(0, 0, 0, 0, 0);
        offer_sample(-16'sd32768);
        offer_sample(16'sd32767);
        offer_sample(16'sd0);
        offer_sample(-16'sd1);
        settle();

        // One 2x2 window, extremes, then equal values reload the entry
        set_map(1, 2, 2, 2, 2);
        offer_sample(-16'sd32768);
        offer_sample(16'sd32767);
        offer_sample(-16'sd1);
        offer_sample(16'sd0);
        repeat (4) offer_sample(-16'sd32768);
        settle();

        // Partial windows: last row and column must be dropped
        set_map(1, 3, 3, 2, 2);
        offer_sample(-16'sd5);
        offer_sample(16'sd7);
        offer_sample(16'sd32767);
        offer_sample(16'sd3);
        offer_sample(-16'sd32768);
        offer_sample(16'sd32767);
        repeat (3) offer_sample(16'sd32767);
        settle();

        // Map smaller than the window gives nothing
        set_map(2, 1, 1, 4, 4);
        offer_sample(16'sd32767);
        offer_sample(-16'sd32768);
        settle();

        // Random phases
        pressure_on <= 1'b1;
        sent       = 0;
        phase_mask = 5'h1f;
        eff_cc = 1;
        eff_h  = 1;
        eff_w  = 1;
        eff_wr = 1;
        eff_wc = 1;
        while (sent < RANDOM_ITEMS) begin
            if (phase_mask[0]) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: eff_cc = $urandom_range(1, 4);
                    6, 7:             eff_cc = $urandom_range(1, 16);
                    8:                eff_cc = 1;
                    default:          eff_cc = 16;
                endcase
                raw = CW'(eff_cc);
                if (eff_cc == 1 && $urandom_range(0, 1) == 1) begin
                    raw = '0;
                end
                if (eff_cc == 16 && $urandom_range(0, 1) == 1) begin
                    raw = CW'($urandom_range(17, 31));
                end
                // Upper bits lie outside the register and are dropped
                raw = raw | CW'($urandom_range(0, 3) << mps_pkg::CC_W);
                write_reg(mps_pkg::REG_CHANNEL_COUNT, raw);
            end
            if (phase_mask[1]) begin
                pick_dim(eff_h, raw);
                write_reg(mps_pkg::REG_IN_HEIGHT, raw);
            end
            if (phase_mask[2]) begin
                pick_dim(eff_w, raw);
                write_reg(mps_pkg::REG_IN_WIDTH, raw);
            end
            if (phase_mask[3]) begin
                eff_wr = $urandom_range(1, 4);
                raw = CW'(eff_wr);
                if (eff_wr == 1 && $urandom_range(0, 1) == 1) begin
                    raw = '0;
                end
                if (eff_wr == 4 && $urandom_range(0, 1) == 1) begin
                    raw = CW'($urandom_range(5, 7));
                end
                raw = raw | CW'($urandom_range(0, 15) << mps_pkg::WIN_W);
                write_reg(mps_pkg::REG_WINDOW_ROWS, raw);
            end
            if (phase_mask[4]) begin
                eff_wc = $urandom_range(1, 4);
                raw = CW'(eff_wc);
                if (eff_wc == 1 && $urandom_range(0, 1) == 1) begin
                    raw = '0;
                end
                if (eff_wc == 4 && $urandom_range(0, 1) == 1) begin
                    raw = CW'($urandom_range(5, 7));
                end
                raw = raw | CW'($urandom_range(0, 15) << mps_pkg::WIN_W);
                write_reg(mps_pkg::REG_WINDOW_COLS, raw);
            end
            // Now and then write an unused index, which must change nothing
            if ($urandom_range(0, 7) == 0) begin
                bad_index = IW'($urandom_range(mps_pkg::REG_WINDOW_COLS + 1,
                                               (1 << mps_pkg::CFG_IDX_W) - 1));
                write_reg(bad_index, CW'($urandom_range(0, 127)));
            end
            end_writes();

            // Whole frames, maybe with a part, for small maps, else a slice
            frame = eff_cc * eff_h * eff_w;
            if (frame <= 300) begin
                n_items = frame * $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 1) begin
                    n_items += $urandom_range(0, frame - 1);
                end
            end else begin
                n_items = $urandom_range(50, 400);
            end
            // Keep the total close to the planned item count
            if (n_items > RANDOM_ITEMS - sent) begin
                n_items = RANDOM_ITEMS - sent;
            end
            repeat (n_items) offer_sample(pick_sample());
            settle();

            sent      += n_items;
            phase_mask = 5'($urandom_range(1, 31));
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
